/* rtl/dst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and constants for the dedup set table: opcodes, status codes,
// controller states and the command / status bundles between the two halves.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int HANDLE_W     = 32;
    localparam int SIZE_W       = 7;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NULL     = 3'd4,
        ST_FULL     = 3'd5,
        ST_CLEARED  = 3'd6,
        ST_LISTED   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_RM_WR,
        S_LIST
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    rd_idx;
        logic    rd_last;
        logic    save_slot;
        logic    wr_append;
        logic    wr_remove;
        logic    clr;
        logic    emit;
        status_t emit_status;
        logic    emit_entry;
        logic    emit_last;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic hzero;
        logic hit;
        logic rd_valid;
        logic idx_end;
        logic full;
        logic cnt_zero;
        logic rd_at_last;
    } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/dst_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dst_datapath
// Entry memory, fill count, scan index, read register and result registers.
// ----------------------------------------------------------------------------
module dst_datapath #(
    parameter int CAPACITY = dst_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [1:0]                    opcode,
    input  wire logic [dst_pkg::HANDLE_W-1:0]  handle,
    input  wire dst_pkg::dp_cmd_t              cmd,
    output dst_pkg::dp_stat_t                  stat,
    output logic [2:0]                         status,
    output logic [dst_pkg::HANDLE_W-1:0]       entry,
    output logic                               has_entry,
    output logic                               last,
    output logic [dst_pkg::SIZE_W-1:0]         set_size,
    output logic                               result_valid
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [dst_pkg::HANDLE_W-1:0] mem [CAPACITY];

    dst_pkg::op_t                 op_reg;
    logic [dst_pkg::HANDLE_W-1:0] handle_reg;
    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                idx_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [IW-1:0]                rd_addr_reg;
    logic [dst_pkg::HANDLE_W-1:0] rdata_reg;
    logic                         rd_valid_reg;
    logic [IW-1:0]                slot_reg;
    logic [IW-1:0]                last_addr;

    dst_pkg::status_t             status_reg;
    logic [dst_pkg::HANDLE_W-1:0] entry_reg;
    logic                         has_entry_reg;
    logic                         last_reg;
    logic [dst_pkg::SIZE_W-1:0]   set_size_reg;
    logic                         result_valid_reg;

    assign last_addr = IW'(count_reg - CW'(1));

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (cmd.wr_append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.wr_remove)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_idx)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            idx_reg          <= '0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            rd_valid_reg     <= cmd.rd_idx | cmd.rd_last;
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= dst_pkg::op_t'(opcode);
            handle_reg <= handle;
        end
        if (cmd.save_slot)
        begin
            slot_reg <= rd_addr_reg;
        end
        if (cmd.emit)
        begin
            status_reg    <= cmd.emit_status;
            entry_reg     <= cmd.emit_entry ? rdata_reg : '0;
            has_entry_reg <= cmd.emit_entry;
            last_reg      <= cmd.emit_last;
            set_size_reg  <= dst_pkg::SIZE_W'(count_next);
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_append)
        begin
            mem[count_reg[IW-1:0]] <= handle_reg;
        end
        else if (cmd.wr_remove)
        begin
            mem[slot_reg] <= rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_idx)
        begin
            rdata_reg   <= mem[idx_reg[IW-1:0]];
            rd_addr_reg <= idx_reg[IW-1:0];
        end
        else if (cmd.rd_last)
        begin
            rdata_reg   <= mem[last_addr];
            rd_addr_reg <= last_addr;
        end
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.hzero      = (handle_reg == '0);
        stat.hit        = rd_valid_reg && (rdata_reg == handle_reg);
        stat.rd_valid   = rd_valid_reg;
        stat.idx_end    = (idx_reg == count_reg);
        stat.full       = (count_reg == CW'(CAPACITY));
        stat.cnt_zero   = (count_reg == '0);
        stat.rd_at_last = ((CW'(rd_addr_reg) + CW'(1)) == count_reg);
    end

    assign status       = status_reg;
    assign entry        = entry_reg;
    assign has_entry    = has_entry_reg;
    assign last         = last_reg;
    assign set_size     = set_size_reg;
    assign result_valid = result_valid_reg;

endmodule
`default_nettype wire

/* rtl/dst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dst_ctrl
// Controller state machine: dispatches the opcode, sequences the entry scan,
// the swap-remove write and the list walk.
// ----------------------------------------------------------------------------
module dst_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire dst_pkg::dp_stat_t stat,
    output dst_pkg::dp_cmd_t       cmd,
    output logic                   busy
);

    dst_pkg::ctrl_state_t state_reg;
    dst_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dst_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = dst_pkg::ST_ADDED;
        cmd.emit_last   = 1'b1;
        case (state_reg)
            dst_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = dst_pkg::S_DISPATCH;
                end
            end
            dst_pkg::S_DISPATCH:
            begin
                case (stat.op)
                    dst_pkg::OP_CLEAR:
                    begin
                        cmd.clr         = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = dst_pkg::ST_CLEARED;
                        state_next      = dst_pkg::S_IDLE;
                    end
                    dst_pkg::OP_LIST:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = dst_pkg::ST_LISTED;
                            state_next      = dst_pkg::S_IDLE;
                        end
                        else
                        begin
                            state_next = dst_pkg::S_LIST;
                        end
                    end
                    default:
                    begin
                        if (stat.hzero)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = dst_pkg::ST_NULL;
                            state_next      = dst_pkg::S_IDLE;
                        end
                        else
                        begin
                            state_next = dst_pkg::S_SCAN;
                        end
                    end
                endcase
            end
            dst_pkg::S_SCAN:
            begin
                if (stat.hit)
                begin
                    if (stat.op == dst_pkg::OP_ADD)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = dst_pkg::ST_PRESENT;
                        state_next      = dst_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.save_slot = 1'b1;
                        cmd.rd_last   = 1'b1;
                        state_next    = dst_pkg::S_RM_WR;
                    end
                end
                else if (stat.idx_end)
                begin
                    cmd.emit   = 1'b1;
                    state_next = dst_pkg::S_IDLE;
                    if (stat.op == dst_pkg::OP_ADD)
                    begin
                        if (stat.full)
                        begin
                            cmd.emit_status = dst_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_append   = 1'b1;
                            cmd.emit_status = dst_pkg::ST_ADDED;
                        end
                    end
                    else
                    begin
                        cmd.emit_status = dst_pkg::ST_NOTFOUND;
                    end
                end
                else
                begin
                    cmd.rd_idx = 1'b1;
                end
            end
            dst_pkg::S_RM_WR:
            begin
                // last entry moves into the freed slot
                cmd.wr_remove   = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = dst_pkg::ST_REMOVED;
                state_next      = dst_pkg::S_IDLE;
            end
            dst_pkg::S_LIST:
            begin
                if (stat.rd_valid)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = dst_pkg::ST_LISTED;
                    cmd.emit_entry  = 1'b1;
                    cmd.emit_last   = stat.rd_at_last;
                    if (stat.rd_at_last)
                    begin
                        state_next = dst_pkg::S_IDLE;
                    end
                end
                if (!stat.idx_end)
                begin
                    cmd.rd_idx = 1'b1;
                end
            end
            default:
            begin
                state_next = dst_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != dst_pkg::S_IDLE);

endmodule
`default_nettype wire

/* rtl/dedup_set_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_set_table
// Unordered set of non-zero handles with add, swap-remove, clear and list.
//
//   channel   signals                                   handshake
//   -------   ---------------------------------------   ---------------------
//   command   opcode, handle                            start & !busy
//   result    status, entry, has_entry, last, set_size  result_valid, 1 cycle
//
// add and remove scan the entries through the single read port of the entry
// memory, one entry per cycle; remove then moves the last entry into the
// freed slot. list gives one result per cycle; clear and a null handle end
// in the dispatch state. reset clears the fill count, not the entries; none
// is read above the count, so there is no clearing pass. results cannot be
// held off; a new command is taken in the cycle the final result shows.
// ----------------------------------------------------------------------------
module dedup_set_table #(
    parameter int CAPACITY = dst_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    opcode,
    input  wire logic [dst_pkg::HANDLE_W-1:0]  handle,
    output logic                               result_valid,
    output logic [2:0]                         status,
    output logic [dst_pkg::HANDLE_W-1:0]       entry,
    output logic                               has_entry,
    output logic                               last,
    output logic [dst_pkg::SIZE_W-1:0]         set_size
);

    dst_pkg::dp_cmd_t  cmd;
    dst_pkg::dp_stat_t stat;

    dst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (opcode),
        .handle       (handle),
        .cmd          (cmd),
        .stat         (stat),
        .status       (status),
        .entry        (entry),
        .has_entry    (has_entry),
        .last         (last),
        .set_size     (set_size),
        .result_valid (result_valid)
    );

    a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last))
        else $error("transaction ended without a final result");

    a_list_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("list burst broken");

    a_entry_only_listed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && has_entry) |-> (status == dst_pkg::ST_LISTED))
        else $error("entry on a non-list result");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (set_size <= dst_pkg::SIZE_W'(CAPACITY)))
        else $error("set size above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule
`default_nettype wire
